>>> design/coordinate_chain_transform_unit_assert.svh
// Assertion macros shared by the transform unit.
// Each macro expands to one labeled concurrent assertion on clk with arst_n as disable.
`ifndef COORDINATE_CHAIN_TRANSFORM_UNIT_ASSERT_SVH
`define COORDINATE_CHAIN_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication: when a holds, c must hold in that cycle.
`define CCT_ASSERT_IMPLIES(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// Next-cycle implication: when a holds, c must hold in the following cycle.
`define CCT_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

>>> design/cct_pkg.sv
package cct_pkg;

	localparam int COORD_W  = 32;
	localparam int COEF_W   = 18;
	localparam int FRAC_W   = 16;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int PROD_W   = COEF_W + DIFF_W;
	localparam int ACC_W    = 54;
	localparam int SHIFT_W  = ACC_W - FRAC_W;
	localparam int ROW_W    = 3 * COEF_W;
	localparam int NUM_AXES = 3;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 6;

	localparam logic [ROW_W-1:0] ROW0_RST = 54'd65536;
	localparam logic [ROW_W-1:0] ROW1_RST = 54'd65536 << COEF_W;
	localparam logic [ROW_W-1:0] ROW2_RST = 54'd65536 << (2 * COEF_W);

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_ROW0  = 3'd0,
		REG_ROW1  = 3'd1,
		REG_ROW2  = 3'd2,
		REG_OFS_X = 3'd3,
		REG_OFS_Y = 3'd4,
		REG_OFS_Z = 3'd5
	} reg_idx_t;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		row_t [NUM_AXES-1:0]              row;
		logic [NUM_AXES-1:0][COORD_W-1:0] offset;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] value;
		logic                      ovf;
	} sat_t;

	// Extracts coefficient k of a packed matrix row.
	function automatic coef_t coef(input row_t row, input logic [1:0] k);
		coef_t c;
		c = coef_t'(row[k*COEF_W +: COEF_W]);
		return c;
	endfunction

	// Rounds a Q.32 sum half up to Q15.16 and clamps it to the 32-bit range.
	function automatic sat_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0]   biased;
		logic signed [SHIFT_W-1:0] sh;
		logic                      top_ones;
		logic                      top_zeros;
		sat_t                      r;
		biased    = acc + ACC_W'(32768);
		sh        = SHIFT_W'(biased >>> FRAC_W);
		top_ones  = &sh[SHIFT_W-1:COORD_W-1];
		top_zeros = ~|sh[SHIFT_W-1:COORD_W-1];
		if (top_ones || top_zeros) begin
			r.value = sh[COORD_W-1:0];
			r.ovf   = 1'b0;
		end else if (sh[SHIFT_W-1]) begin
			r.value = COORD_MIN;
			r.ovf   = 1'b1;
		end else begin
			r.value = COORD_MAX;
			r.ovf   = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> design/cct_regs.sv
module cct_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cct_pkg::ADDR_W-1:0]   paddr,
	input  logic [cct_pkg::DATA_W-1:0]   pwdata,
	output logic [cct_pkg::DATA_W-1:0]   prdata,
	output cct_pkg::cfg_t                cfg
);

	cct_pkg::cfg_t     cfg_q;
	cct_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx   = cct_pkg::reg_idx_t'(paddr[cct_pkg::ADDR_W-1:3]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row[0]    <= cct_pkg::ROW0_RST;
			cfg_q.row[1]    <= cct_pkg::ROW1_RST;
			cfg_q.row[2]    <= cct_pkg::ROW2_RST;
			cfg_q.offset[0] <= '0;
			cfg_q.offset[1] <= '0;
			cfg_q.offset[2] <= '0;
		end else if (wr_en) begin
			case (idx)
				cct_pkg::REG_ROW0:  cfg_q.row[0]    <= pwdata[cct_pkg::ROW_W-1:0];
				cct_pkg::REG_ROW1:  cfg_q.row[1]    <= pwdata[cct_pkg::ROW_W-1:0];
				cct_pkg::REG_ROW2:  cfg_q.row[2]    <= pwdata[cct_pkg::ROW_W-1:0];
				cct_pkg::REG_OFS_X: cfg_q.offset[0] <= pwdata[cct_pkg::COORD_W-1:0];
				cct_pkg::REG_OFS_Y: cfg_q.offset[1] <= pwdata[cct_pkg::COORD_W-1:0];
				cct_pkg::REG_OFS_Z: cfg_q.offset[2] <= pwdata[cct_pkg::COORD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			cct_pkg::REG_ROW0:  prdata = cct_pkg::DATA_W'(cfg_q.row[0]);
			cct_pkg::REG_ROW1:  prdata = cct_pkg::DATA_W'(cfg_q.row[1]);
			cct_pkg::REG_ROW2:  prdata = cct_pkg::DATA_W'(cfg_q.row[2]);
			cct_pkg::REG_OFS_X: prdata = cct_pkg::DATA_W'(cfg_q.offset[0]);
			cct_pkg::REG_OFS_Y: prdata = cct_pkg::DATA_W'(cfg_q.offset[1]);
			cct_pkg::REG_OFS_Z: prdata = cct_pkg::DATA_W'(cfg_q.offset[2]);
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> design/coordinate_chain_transform_unit.sv
// A point accepted into stage 1 moves through stage 2 and the stage 3 output register before it shows on m_tvalid.
// One point per cycle while m_tready is high; the three pipeline stages each hold one transaction.
// Only a stalled output (m_tready low) slows intake, once all three stages are full.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the identity
// matrix and a zero offset into the configuration registers.
module coordinate_chain_transform_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port; register i lives at byte address 8*i.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cct_pkg::ADDR_W-1:0]          paddr,
	input  logic [cct_pkg::DATA_W-1:0]          pwdata,
	output logic [cct_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [3*cct_pkg::COORD_W-1:0]       s_tdata,   // pos_x, pos_y, pos_z
	input  logic                                s_tuser,   // op
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [3*cct_pkg::COORD_W-1:0]       m_tdata,   // out_x, out_y, out_z
	output logic                                m_tuser    // overflow
);

	`include "coordinate_chain_transform_unit_assert.svh"

	// The configuration is held in a small register file. Software must only
	// rewrite it while no transaction is in flight (the block does not enforce
	// this), so every stage reads the live values directly.
	cct_pkg::cfg_t cfg;

	cct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// Each stage advances when it is empty or the stage after it advances.
	// This lets bubbles close up behind a stalled output, so intake continues
	// until all three stages are occupied.
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	// Stage 1: operand vector. The forward direction uses the point itself;
	// the inverse direction first removes the translation. The difference is
	// kept exact at 33 bits.
	logic                                   op_s1;
	logic signed [cct_pkg::DIFF_W-1:0]      opnd_s1 [cct_pkg::NUM_AXES];
	logic signed [cct_pkg::DIFF_W-1:0]      opnd_c  [cct_pkg::NUM_AXES];

	always_comb begin
		for (int j = 0; j < cct_pkg::NUM_AXES; j++) begin
			logic signed [cct_pkg::DIFF_W-1:0] p_ext;
			logic signed [cct_pkg::DIFF_W-1:0] t_ext;
			p_ext = cct_pkg::DIFF_W'($signed(s_tdata[j*cct_pkg::COORD_W +: cct_pkg::COORD_W]));
			t_ext = cct_pkg::DIFF_W'($signed(cfg.offset[j]));
			opnd_c[j] = s_tuser ? (p_ext - t_ext) : p_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && adv1) begin
			op_s1 <= s_tuser;
			for (int j = 0; j < cct_pkg::NUM_AXES; j++) begin
				opnd_s1[j] <= opnd_c[j];
			end
		end
	end

	// Stage 2: nine exact products. The inverse direction walks the matrix
	// by columns, which is the transpose of A.
	logic                                   op_s2;
	logic signed [cct_pkg::PROD_W-1:0]      prod_s2 [cct_pkg::NUM_AXES][cct_pkg::NUM_AXES];
	logic signed [cct_pkg::PROD_W-1:0]      prod_c  [cct_pkg::NUM_AXES][cct_pkg::NUM_AXES];

	always_comb begin
		for (int i = 0; i < cct_pkg::NUM_AXES; i++) begin
			for (int j = 0; j < cct_pkg::NUM_AXES; j++) begin
				cct_pkg::coef_t c;
				if (op_s1) begin
					c = cct_pkg::coef(cfg.row[j], 2'(i));
				end else begin
					c = cct_pkg::coef(cfg.row[i], 2'(j));
				end
				prod_c[i][j] = cct_pkg::PROD_W'(c) * cct_pkg::PROD_W'(opnd_s1[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv2) begin
			op_s2 <= op_s1;
			for (int i = 0; i < cct_pkg::NUM_AXES; i++) begin
				for (int j = 0; j < cct_pkg::NUM_AXES; j++) begin
					prod_s2[i][j] <= prod_c[i][j];
				end
			end
		end
	end

	// Stage 3: each row sum (plus the scaled offset in the forward direction)
	// is rounded once and saturated into the output register.
	logic signed [cct_pkg::COORD_W-1:0]     out_s3 [cct_pkg::NUM_AXES];
	logic                                   ovf_s3;
	cct_pkg::sat_t                          sat_c  [cct_pkg::NUM_AXES];

	always_comb begin
		for (int i = 0; i < cct_pkg::NUM_AXES; i++) begin
			logic signed [cct_pkg::ACC_W-1:0] ofs;
			logic signed [cct_pkg::ACC_W-1:0] acc;
			if (op_s2) begin
				ofs = '0;
			end else begin
				ofs = $signed({{(cct_pkg::ACC_W - cct_pkg::COORD_W - cct_pkg::FRAC_W)
					{cfg.offset[i][cct_pkg::COORD_W-1]}},
					cfg.offset[i], {cct_pkg::FRAC_W{1'b0}}});
			end
			acc = cct_pkg::ACC_W'(prod_s2[i][0]) + cct_pkg::ACC_W'(prod_s2[i][1])
				+ cct_pkg::ACC_W'(prod_s2[i][2]) + ofs;
			sat_c[i] = cct_pkg::round_sat(acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && adv3) begin
			for (int i = 0; i < cct_pkg::NUM_AXES; i++) begin
				out_s3[i] <= sat_c[i].value;
			end
			ovf_s3 <= sat_c[0].ovf || sat_c[1].ovf || sat_c[2].ovf;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {out_s3[2], out_s3[1], out_s3[0]};
	assign m_tuser  = ovf_s3;

	// Short terms used by the checks below.
	logic pipe_full;
	logic s2_stall;
	logic at_limit;

	assign pipe_full = v_s1 && v_s2 && v_s3;
	assign s2_stall  = v_s2 && !adv3;
	assign at_limit  = (out_s3[0] == cct_pkg::COORD_MAX) || (out_s3[0] == cct_pkg::COORD_MIN)
		|| (out_s3[1] == cct_pkg::COORD_MAX) || (out_s3[1] == cct_pkg::COORD_MIN)
		|| (out_s3[2] == cct_pkg::COORD_MAX) || (out_s3[2] == cct_pkg::COORD_MIN);

	// Intake only stops when every stage holds a transaction and the output
	// is stalled.
	`CCT_ASSERT_IMPLIES(a_intake_stall, !s_tready, pipe_full && !m_tready, "intake stalled with room")

	// A stage 2 transaction that cannot move must stay valid and keep its direction and its first product.
	`CCT_ASSERT_NEXT(a_s2_hold, s2_stall, v_s2 && $stable(op_s2) && $stable(prod_s2[0][0]), "s2 lost")

	// The overflow flag is only raised when some coordinate sits at a limit.
	`CCT_ASSERT_IMPLIES(a_ovf_limit, m_tvalid && m_tuser, at_limit, "overflow without saturation")

endmodule

>>> bench/coordinate_chain_transform_unit_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the coordinate transform unit.
// Points go in on the slave stream, transformed points come back on the master stream,
// and an in-bench predictor works out every expected point from its own copy of the
// matrix and offset registers.
module coordinate_chain_transform_unit_tb;
	import cct_pkg::*;

	// Direction carried in tuser of the input stream.
	localparam logic OP_FORWARD = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	// Register indexes past the last real register; writes there must be ignored.
	localparam int unsigned REG_SPARE_LO = 6;
	localparam int unsigned REG_SPARE_HI = 7;

	localparam int PIPE_DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int POINTS_PER_PHASE = 240;

	// Unity coefficient in Q1.16 and the coefficient extremes.
	localparam int COEF_ONE = 65536;
	localparam int COEF_HALF = 32768;
	localparam int COEF_TOP = 131071;
	localparam int COEF_BOTTOM = -131072;

	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      ovf;
	} point_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [3*COORD_W-1:0]    s_tdata = '0;   // pos_x, pos_y, pos_z
	logic                    s_tuser = 1'b0; // op
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [3*COORD_W-1:0]    m_tdata;        // out_x, out_y, out_z
	logic                    m_tuser;        // overflow

	// Bench copy of the configuration registers, loaded with the reset values.
	row_t                      cfg_row [3] = '{ROW0_RST, ROW1_RST, ROW2_RST};
	logic signed [COORD_W-1:0] cfg_ofs [3] = '{32'sd0, 32'sd0, 32'sd0};

	point_item_t   pending_points [$];
	point_result_t expected_points [$];

	int  points_queued = 0;
	int  results_seen = 0;
	int  error_count = 0;
	int  cycle_count = 0;
	int  src_gap = 0;
	int  snk_gap = 0;
	bit  src_accept = 1'b0;
	bit  idle_on = 1'b1;

	coordinate_chain_transform_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Rounds a Q.32 sum half up to Q15.16 and clamps it, raising sat when clamped.
	function automatic logic signed [COORD_W-1:0] round_clamp(input longint acc,
			inout logic sat);
		longint r;
		r = (acc + 64'sd32768) >>> FRAC_W;
		if (r > 64'sd2147483647) begin
			sat = 1'b1;
			return COORD_MAX;
		end else if (r < -64'sd2147483648) begin
			sat = 1'b1;
			return COORD_MIN;
		end
		return r[COORD_W-1:0];
	endfunction

	// Forward direction: A*p + t. Inverse direction: A-transpose*(p - t), with the
	// difference kept at full width so nothing saturates before the multiply.
	function automatic point_result_t transform_point(input logic op,
			input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
			input logic signed [COORD_W-1:0] pz);
		longint        m [3][3];
		longint        p [3];
		longint        t [3];
		longint        d [3];
		longint        acc;
		logic          sat;
		logic signed [COORD_W-1:0] v [3];
		point_result_t res;
		sat = 1'b0;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		for (int i = 0; i < 3; i++) begin
			t[i] = cfg_ofs[i];
			d[i] = p[i] - t[i];
			for (int j = 0; j < 3; j++) begin
				m[i][j] = $signed(cfg_row[i][j*COEF_W +: COEF_W]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (op == OP_FORWARD) begin
				acc = t[i] * 65536;
				for (int j = 0; j < 3; j++) acc += m[i][j] * p[j];
			end else begin
				acc = 0;
				for (int j = 0; j < 3; j++) acc += m[j][i] * d[j];
			end
			v[i] = round_clamp(acc, sat);
		end
		res.x = v[0];
		res.y = v[1];
		res.z = v[2];
		res.ovf = sat;
		return res;
	endfunction

	function automatic row_t pack_row(input int c0, input int c1, input int c2);
		return {coef_t'(c2), coef_t'(c1), coef_t'(c0)};
	endfunction

	// Mostly workpiece-sized coordinates, with full-range values and the extremes mixed in.
	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		endcase
	endfunction

	// APB write followed, for the real registers, by a read-back of the stored value.
	task automatic apb_write(input int unsigned idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] mask;
		mask = (idx <= REG_ROW2) ? {{(DATA_W-ROW_W){1'b0}}, {ROW_W{1'b1}}}
			: {{(DATA_W-COORD_W){1'b0}}, {COORD_W{1'b1}}};
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 8);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_ROW0:  cfg_row[0] = value[ROW_W-1:0];
			REG_ROW1:  cfg_row[1] = value[ROW_W-1:0];
			REG_ROW2:  cfg_row[2] = value[ROW_W-1:0];
			REG_OFS_X: cfg_ofs[0] = value[COORD_W-1:0];
			REG_OFS_Y: cfg_ofs[1] = value[COORD_W-1:0];
			REG_OFS_Z: cfg_ofs[2] = value[COORD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		if (idx <= REG_OFS_Z) begin
			// psel stays high; this cycle is the setup phase of the read.
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if ((prdata & mask) !== (value & mask))
				report_mismatch($sformatf("register %0d read 0x%0h expected 0x%0h", idx,
					prdata & mask, value & mask));
			@(negedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_config(input row_t r0, input row_t r1, input row_t r2,
			input logic signed [COORD_W-1:0] ox, input logic signed [COORD_W-1:0] oy,
			input logic signed [COORD_W-1:0] oz);
		apb_write(REG_ROW0, DATA_W'(r0));
		apb_write(REG_ROW1, DATA_W'(r1));
		apb_write(REG_ROW2, DATA_W'(r2));
		apb_write(REG_OFS_X, DATA_W'(unsigned'(ox)));
		apb_write(REG_OFS_Y, DATA_W'(unsigned'(oy)));
		apb_write(REG_OFS_Z, DATA_W'(unsigned'(oz)));
	endtask

	// Picks a new frame: a rotation about one axis, a signed axis swap, or raw
	// coefficients that need not be orthonormal at all.
	task automatic load_random_config(input int shape);
		int   m [3][3];
		int   perm [3];
		int   k, u, v, tmp, c, s;
		real  ang;
		logic signed [COORD_W-1:0] ofs [3];
		for (int i = 0; i < 3; i++) begin
			perm[i] = i;
			for (int j = 0; j < 3; j++) m[i][j] = 0;
		end
		case (shape)
			0: begin
				k = $urandom_range(0, 2);
				u = (k + 1) % 3;
				v = (k + 2) % 3;
				ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
				c = int'($cos(ang) * 65536.0);
				s = int'($sin(ang) * 65536.0);
				m[k][k] = COEF_ONE;
				m[u][u] = c;
				m[u][v] = -s;
				m[v][u] = s;
				m[v][v] = c;
			end
			1: begin
				for (int i = 2; i > 0; i--) begin
					k = $urandom_range(0, i);
					tmp = perm[i];
					perm[i] = perm[k];
					perm[k] = tmp;
				end
				for (int i = 0; i < 3; i++)
					m[i][perm[i]] = $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
			end
			default: begin
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) m[i][j] = $urandom_range(0, 262143);
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 3))
				0: ofs[i] = $urandom;
				1: ofs[i] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
				default: ofs[i] = rand_coord();
			endcase
		end
		load_config(pack_row(m[0][0], m[0][1], m[0][2]), pack_row(m[1][0], m[1][1], m[1][2]),
			pack_row(m[2][0], m[2][1], m[2][2]), ofs[0], ofs[1], ofs[2]);
	endtask

	task automatic queue_point(input logic op, input logic signed [COORD_W-1:0] x,
			input logic signed [COORD_W-1:0] y, input logic signed [COORD_W-1:0] z);
		point_item_t item;
		item.op = op;
		item.x = x;
		item.y = y;
		item.z = z;
		pending_points.push_back(item);
		points_queued++;
	endtask

	// Holds the sender back until every queued point has come out the other side.
	// results_seen changes only at rising edges, so checking at falling edges is race free.
	task automatic wait_for_results();
		while (results_seen != points_queued) @(negedge clk);
	endtask

	// Source driver: a new transaction is offered only once the previous one was
	// accepted, and while idling is on, random gaps are inserted between transactions.
	always @(negedge clk) begin : source_driver
		point_item_t item;
		if (!s_tvalid || src_accept) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_points.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				src_gap = $urandom_range(0, 8);
				s_tvalid <= 1'b0;
			end else begin
				item = pending_points.pop_front();
				s_tdata <= {item.z, item.y, item.x};
				s_tuser <= item.op;
				s_tvalid <= 1'b1;
			end
		end
	end

	// Sink driver: while idling is on, random bursts of back-pressure on the result stream.
	always @(negedge clk) begin : sink_driver
		if (snk_gap > 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			snk_gap = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: every accepted input transaction is predicted at once, since the
	// configuration only changes while nothing is in flight. Every accepted result
	// transaction is checked against the oldest prediction.
	always @(posedge clk) begin : stream_monitor
		point_result_t want;
		point_result_t got;
		if (arst_n) begin
			src_accept = s_tvalid && s_tready;
			if (src_accept)
				expected_points.push_back(transform_point(s_tuser, s_tdata[COORD_W-1:0],
					s_tdata[2*COORD_W-1:COORD_W], s_tdata[3*COORD_W-1:2*COORD_W]));
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[COORD_W-1:0];
				got.y = m_tdata[2*COORD_W-1:COORD_W];
				got.z = m_tdata[3*COORD_W-1:2*COORD_W];
				got.ovf = m_tuser;
				if (expected_points.size() == 0) begin
					report_mismatch("result transaction with no point outstanding");
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x)
						report_mismatch($sformatf("out_x %0d expected %0d", got.x, want.x));
					if (got.y !== want.y)
						report_mismatch($sformatf("out_y %0d expected %0d", got.y, want.y));
					if (got.z !== want.z)
						report_mismatch($sformatf("out_z %0d expected %0d", got.z, want.z));
					if (got.ovf !== want.ovf)
						report_mismatch($sformatf("overflow %0b expected %0b", got.ovf, want.ovf));
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("coordinate_chain_transform_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset frame is the identity with no offset, so forward points come back
		// unchanged, extremes included.
		queue_point(OP_FORWARD, 32'sd0, 32'sd0, 32'sd0);
		queue_point(OP_FORWARD, COORD_MAX, COORD_MIN, -32'sd1);
		queue_point(OP_INVERSE, COORD_MIN, COORD_MAX, 32'sd1);
		queue_point(OP_FORWARD, 32'sd1, -32'sd1, 32'sh1234_5678);
		queue_point(OP_INVERSE, COORD_MAX, COORD_MAX, COORD_MAX);
		wait_for_results();

		// Extreme frame: largest and smallest coefficients, offsets at both rails.
		// Forward points saturate high and low; inverse points make the difference
		// p - t need the extra bit.
		load_config(pack_row(COEF_TOP, COEF_TOP, COEF_TOP),
			pack_row(COEF_BOTTOM, COEF_BOTTOM, COEF_BOTTOM),
			pack_row(COEF_TOP, COEF_BOTTOM, 0), COORD_MAX, COORD_MIN, 32'sd0);
		queue_point(OP_FORWARD, COORD_MAX, COORD_MAX, COORD_MAX);
		queue_point(OP_FORWARD, 32'sd0, 32'sd0, 32'sd0);
		queue_point(OP_FORWARD, COORD_MIN, COORD_MIN, COORD_MIN);
		queue_point(OP_INVERSE, COORD_MAX, COORD_MIN, 32'sd0);
		queue_point(OP_INVERSE, COORD_MIN, COORD_MAX, COORD_MAX);
		queue_point(OP_INVERSE, 32'sd0, 32'sd0, 32'sd0);
		wait_for_results();

		// Half coefficients put the rounding right on the half-way point, and the
		// frame is deliberately not orthonormal. The row 2 and offset Z writes carry
		// stray upper bits that the register must drop, and writes past the last
		// register must leave everything as it was.
		load_config(pack_row(COEF_HALF, 0, 0), pack_row(0, -COEF_HALF, 0),
			pack_row(COEF_HALF, COEF_HALF, COEF_TOP), 32'sd0, 32'sd0, 32'sd0);
		apb_write(REG_ROW2, {10'h3FF, pack_row(0, COEF_HALF, COEF_TOP)});
		apb_write(REG_OFS_Z, 64'hFFFF_FFFF_8000_0000);
		apb_write(REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(REG_SPARE_HI, 64'h5A5A_5A5A_5A5A_5A5A);
		queue_point(OP_FORWARD, 32'sd1, 32'sd1, 32'sd0);
		queue_point(OP_FORWARD, -32'sd1, -32'sd1, 32'sd0);
		queue_point(OP_FORWARD, 32'sd3, -32'sd3, 32'sd7);
		queue_point(OP_INVERSE, 32'sd1, -32'sd1, 32'sd0);
		queue_point(OP_INVERSE, -32'sd3, 32'sd3, COORD_MIN);
		queue_point(OP_INVERSE, COORD_MAX, COORD_MIN, COORD_MAX);
		wait_for_results();

		// Random part: a fresh frame per phase, the sender held back at each phase
		// boundary, and no idling in the final phase.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			idle_on = (ph < RANDOM_PHASES - 1);
			load_random_config(ph % 3);
			if (ph == 4) begin
				apb_write(REG_OFS_X, {$urandom, 32'(cfg_ofs[0])});
				apb_write(REG_SPARE_LO, {$urandom, $urandom});
			end
			for (int n = 0; n < POINTS_PER_PHASE; n++)
				queue_point($urandom_range(0, 1) ? OP_INVERSE : OP_FORWARD, rand_coord(),
					rand_coord(), rand_coord());
			wait_for_results();
		end

		repeat (PIPE_DRAIN_CYCLES) @(negedge clk);
		if (expected_points.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_points.size()));
		if (error_count == 0) begin
			$display("coordinate_chain_transform_unit_tb OK");
		end else begin
			$display("coordinate_chain_transform_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> coordinate_chain_transform_unit.f
+incdir+design
design/cct_pkg.sv
design/cct_regs.sv
design/coordinate_chain_transform_unit.sv
bench/coordinate_chain_transform_unit_tb.sv
